// File: hdl/nups_pkg.sv
// ----------------------------------------------------------------------------
// nups_pkg
// Shared types and constants for the nearest unvisited point search unit.
// ----------------------------------------------------------------------------
package nups_pkg;

  localparam int COORD_W = 16;
  localparam int SLOT_W  = 8;
  localparam int LABEL_W = 16;
  localparam int DIST_W  = 34;
  localparam int CFG_W   = 9;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_MARK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    op_t                       operation;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [LABEL_W-1:0]        point_label;
  } in_req_t;

  typedef struct packed {
    logic                      found;
    logic [SLOT_W-1:0]         nearest_slot;
    logic [LABEL_W-1:0]        nearest_label;
    logic signed [COORD_W-1:0] nearest_x;
    logic signed [COORD_W-1:0] nearest_y;
    logic [DIST_W-1:0]         squared_distance;
    logic                      all_visited;
  } out_rsp_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [LABEL_W-1:0]        label;
  } point_t;

endpackage

// File: hdl/nups_ram.sv
// ----------------------------------------------------------------------------
// nups_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module nups_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/nups_dist.sv
// ----------------------------------------------------------------------------
// nups_dist
// Squared distance unit: registered squares of dx and dy, then their sum.
// ----------------------------------------------------------------------------
module nups_dist (
  input  logic                               clk,
  input  nups_pkg::point_t                   pt,
  input  logic signed [nups_pkg::COORD_W-1:0] qx,
  input  logic signed [nups_pkg::COORD_W-1:0] qy,
  output logic [nups_pkg::DIST_W-1:0]        sq_dist
);
  import nups_pkg::*;

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [2*COORD_W+1:0] prod_x;
  logic signed [2*COORD_W+1:0] prod_y;
  logic [2*COORD_W:0]          sq_x_r;
  logic [2*COORD_W:0]          sq_y_r;

  assign dx     = {pt.x[COORD_W-1], pt.x} - {qx[COORD_W-1], qx};
  assign dy     = {pt.y[COORD_W-1], pt.y} - {qy[COORD_W-1], qy};
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  always_ff @(posedge clk) begin
    sq_x_r <= prod_x[2*COORD_W:0];
    sq_y_r <= prod_y[2*COORD_W:0];
  end

  assign sq_dist = DIST_W'({1'b0, sq_x_r} + {1'b0, sq_y_r});

endmodule

// File: hdl/nearest_unvisited_point_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_unvisited_point_search_unit
// Point table with visited flags and a linear nearest-unvisited-point scan.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready/in_req: write a point, mark or clear
// a slot's visited flag, or query with a coordinate. Every request returns
// one response on out_valid/out_ready/out_rsp. cfg_we/cfg_data write
// points_in_use (clamped to MAX_POINTS); the user must do so only while the
// unit is idle, as the unit does not enforce it. Each request applies its
// table update at acceptance, then scans slots 0..n-1 (n = clamped
// points_in_use) through the point memory, one slot per cycle, through a
// two-stage squared-distance and compare pipe. The response is loaded into
// the output register once the pipe has drained and the output register is
// free, and in_ready rises with it.
// The rate is set by the single read port of the point memory.
// One request is in flight at a time. A new request is accepted while the
// previous response still waits in the output register; if the receiver
// stalls, the finished scan holds until the output register frees.
// Reset (synchronous, active low) clears all visited flags, points_in_use
// and the control state; point memory contents are undefined until written.
// ----------------------------------------------------------------------------
module nearest_unvisited_point_search_unit #(
  parameter int MAX_POINTS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  nups_pkg::in_req_t              in_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output nups_pkg::out_rsp_t             out_rsp,
  input  logic                           cfg_we,
  input  logic [nups_pkg::CFG_W-1:0]     cfg_data
);
  import nups_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CFG_W-1:0]          pts_r, pts_nxt;
  logic [MAX_POINTS-1:0]     visited_r, visited_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic                      query_r, query_nxt;
  logic signed [COORD_W-1:0] qx_r, qx_nxt;
  logic signed [COORD_W-1:0] qy_r, qy_nxt;
  logic                      all_vis_r, all_vis_nxt;
  logic                      s1_vld_r, s1_vld_nxt;
  logic [IW-1:0]             s1_idx_r, s1_idx_nxt;
  logic                      s1_unv_r, s1_unv_nxt;
  logic                      s2_vld_r, s2_vld_nxt;
  logic [IW-1:0]             s2_idx_r, s2_idx_nxt;
  logic                      s2_unv_r, s2_unv_nxt;
  point_t                    s2_pt_r, s2_pt_nxt;
  logic                      have_r, have_nxt;
  logic [IW-1:0]             best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0]         best_d_r, best_d_nxt;
  point_t                    best_pt_r, best_pt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_rsp_t                  out_rsp_r, out_rsp_nxt;

  logic                      in_accept;
  logic                      slot_ok;
  logic                      ram_we;
  logic [IW-1:0]             raddr;
  point_t                    wr_pt;
  point_t                    rd_pt;
  logic                      vis_rd;
  logic                      issue;
  logic                      scan_end;
  logic                      better;
  logic [DIST_W-1:0]         pt_dist;
  logic [CW-1:0]             n_clamp;

  nups_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (IW'(in_req.slot)),
    .wr_data (wr_pt),
    .rd_addr (raddr),
    .rd_data (rd_pt)
  );

  nups_dist u_dist (
    .clk     (clk),
    .pt      (rd_pt),
    .qx      (qx_r),
    .qy      (qy_r),
    .sq_dist (pt_dist)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign slot_ok   = (32'(in_req.slot) < 32'(MAX_POINTS));
  assign ram_we    = in_accept && (in_req.operation == OP_WRITE) && slot_ok;
  assign wr_pt.x     = in_req.coord_x;
  assign wr_pt.y     = in_req.coord_y;
  assign wr_pt.label = in_req.point_label;

  assign raddr    = idx_r[IW-1:0];
  assign vis_rd   = visited_r[raddr];
  assign issue    = (state_r == ST_SCAN) && (idx_r < n_r);
  assign scan_end = (state_r == ST_SCAN) && !issue && !s1_vld_r && !s2_vld_r;
  assign better   = s2_vld_r && s2_unv_r && query_r && (!have_r || (pt_dist < best_d_r));
  assign n_clamp  = (NW'(pts_r) > NW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(pts_r);

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_comb begin
    state_nxt     = state_r;
    pts_nxt       = cfg_we ? cfg_data : pts_r;
    visited_nxt   = visited_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    query_nxt     = query_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    all_vis_nxt   = all_vis_r;
    s1_vld_nxt    = issue;
    s1_idx_nxt    = raddr;
    s1_unv_nxt    = !vis_rd;
    s2_vld_nxt    = s1_vld_r;
    s2_idx_nxt    = s1_idx_r;
    s2_unv_nxt    = s1_unv_r;
    s2_pt_nxt     = rd_pt;
    have_nxt      = have_r;
    best_idx_nxt  = best_idx_r;
    best_d_nxt    = best_d_r;
    best_pt_nxt   = best_pt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt   = ST_SCAN;
          idx_nxt     = '0;
          n_nxt       = n_clamp;
          all_vis_nxt = 1'b1;
          have_nxt    = 1'b0;
          query_nxt   = (in_req.operation == OP_QUERY);
          qx_nxt      = in_req.coord_x;
          qy_nxt      = in_req.coord_y;
          if (slot_ok) begin
            case (in_req.operation)
              OP_WRITE: visited_nxt[IW'(in_req.slot)] = 1'b0;
              OP_MARK:  visited_nxt[IW'(in_req.slot)] = 1'b1;
              OP_CLEAR: visited_nxt[IW'(in_req.slot)] = 1'b0;
              default:  visited_nxt = visited_r;
            endcase
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_nxt     = idx_r + 1'b1;
          all_vis_nxt = all_vis_r && vis_rd;
        end
        if (better) begin
          have_nxt     = 1'b1;
          best_idx_nxt = s2_idx_r;
          best_d_nxt   = pt_dist;
          best_pt_nxt  = s2_pt_r;
        end
        if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt                    = ST_IDLE;
          out_valid_nxt                = 1'b1;
          out_rsp_nxt.found            = have_r;
          out_rsp_nxt.nearest_slot     = have_r ? SLOT_W'(best_idx_r) : '0;
          out_rsp_nxt.nearest_label    = have_r ? best_pt_r.label : '0;
          out_rsp_nxt.nearest_x        = have_r ? best_pt_r.x : '0;
          out_rsp_nxt.nearest_y        = have_r ? best_pt_r.y : '0;
          out_rsp_nxt.squared_distance = have_r ? best_d_r : '0;
          out_rsp_nxt.all_visited      = all_vis_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pts_r       <= '0;
      visited_r   <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pts_r       <= pts_nxt;
      visited_r   <= visited_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    query_r    <= query_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    all_vis_r  <= all_vis_nxt;
    s1_idx_r   <= s1_idx_nxt;
    s1_unv_r   <= s1_unv_nxt;
    s2_idx_r   <= s2_idx_nxt;
    s2_unv_r   <= s2_unv_nxt;
    s2_pt_r    <= s2_pt_nxt;
    best_idx_r <= best_idx_nxt;
    best_d_r   <= best_d_nxt;
    best_pt_r  <= best_pt_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a scan was starting");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r || s2_vld_r) |-> (state_r == ST_SCAN))
    else $error("scan pipe active outside scan");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= n_r))
    else $error("scan index past slot count");

  a_found_not_all: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.found |-> !out_rsp.all_visited)
    else $error("found point while all visited");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.found |-> (out_rsp.squared_distance == '0) &&
                                    (out_rsp.nearest_slot == '0))
    else $error("miss response carries nonzero fields");

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_unvisited_point_search_unit.
// ----------------------------------------------------------------------------
// A local point table with visited flags tracks every accepted request and
// predicts its response. A separate process checks each response in order.
// The whole table is loaded first, so no scan reads an unwritten slot.
// After that come directed cases: the empty table, ties, the extreme
// distance, all points visited, clamping of points_in_use and a write that
// clears a visited flag. Then come nearest-neighbor tours and random request
// mixes at several table sizes. The sender idles in bursts, the receiver
// stalls, and one long receiver hold-off fills the unit so it stalls input.
// ----------------------------------------------------------------------------
module testbench;
  import nups_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS = 256;
  localparam int HOLD_CYCLES = 400;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  in_req_t          in_req    = '0;
  logic             out_ready = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_ready;
  logic             out_valid;
  out_rsp_t         out_rsp;

  // local copy of the point table and register
  logic signed [COORD_W-1:0] pt_x [MAX_PTS];
  logic signed [COORD_W-1:0] pt_y [MAX_PTS];
  logic [LABEL_W-1:0]        pt_label [MAX_PTS];
  bit                        pt_visited [MAX_PTS];
  logic [CFG_W-1:0]          points_cfg = '0;

  out_rsp_t rsp_due [$];
  int       mismatches = 0;

  // sender and receiver pacing
  bit idle_on     = 1'b0;
  int burst_left  = 0;
  int stall_pct   = 0;
  int stall_left  = 0;
  bit hold_pending = 1'b0;

  nearest_unvisited_point_search_unit #(.MAX_POINTS(MAX_PTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int scan_count();
    return (points_cfg > MAX_PTS) ? MAX_PTS : int'(points_cfg);
  endfunction

  // apply one request to the local table and return its response
  function automatic out_rsp_t search_nearest(input in_req_t r);
    out_rsp_t res;
    int       n;
    bit       have;
    longint   dx, dy, d, best_d;
    res = '0;
    n = scan_count();
    have = 1'b0;
    best_d = 0;
    case (r.operation)
      OP_WRITE: begin
        pt_x[r.slot] = r.coord_x;
        pt_y[r.slot] = r.coord_y;
        pt_label[r.slot] = r.point_label;
        pt_visited[r.slot] = 1'b0;
      end
      OP_MARK:  pt_visited[r.slot] = 1'b1;
      OP_CLEAR: pt_visited[r.slot] = 1'b0;
      OP_QUERY: begin
        for (int i = 0; i < n; i++) begin
          if (!pt_visited[i]) begin
            dx = longint'(pt_x[i]) - longint'(r.coord_x);
            dy = longint'(pt_y[i]) - longint'(r.coord_y);
            d = dx * dx + dy * dy;
            if (!have || d < best_d) begin
              have = 1'b1;
              best_d = d;
              res.found = 1'b1;
              res.nearest_slot = 8'(i);
              res.nearest_label = pt_label[i];
              res.nearest_x = pt_x[i];
              res.nearest_y = pt_y[i];
              res.squared_distance = d[DIST_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    res.all_visited = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!pt_visited[i]) res.all_visited = 1'b0;
    end
    return res;
  endfunction

  function automatic in_req_t make_req(input op_t op, input int s,
                                       input logic signed [COORD_W-1:0] x,
                                       input logic signed [COORD_W-1:0] y,
                                       input logic [LABEL_W-1:0] lab);
    in_req_t r;
    r.operation = op;
    r.slot = 8'(s);
    r.coord_x = x;
    r.coord_y = y;
    r.point_label = lab;
    return r;
  endfunction

  // near values cluster around the origin so that ties come up
  function automatic logic signed [COORD_W-1:0] rand_coord(input bit near);
    int v;
    v = near ? int'($urandom_range(0, 16)) - 8 : int'($urandom_range(0, 65535));
    return v[COORD_W-1:0];
  endfunction

  task automatic send_req(input in_req_t r, output out_rsp_t want);
    @(posedge clk);
    if (idle_on) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 14)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    want = search_nearest(r);
    rsp_due.push_back(want);
  endtask

  task automatic wait_drain();
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_points(input int n);
    wait_drain();
    cfg_we   <= 1'b1;
    cfg_data <= CFG_W'(n);
    @(posedge clk);
    cfg_we <= 1'b0;
    points_cfg = CFG_W'(n);
  endtask

  task automatic set_pacing(input bit idle, input int pct);
    idle_on = idle;
    burst_left = 0;
    stall_pct = pct;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic flag_field(input string field, input logic [63:0] e,
                            input logic [63:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", field, e, a);
    end
  endtask

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rsp_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", out_rsp);
      end else begin
        want = rsp_due.pop_front();
        flag_field("found", 64'(want.found), 64'(out_rsp.found));
        flag_field("nearest_slot", 64'(want.nearest_slot),
                   64'(out_rsp.nearest_slot));
        flag_field("nearest_label", 64'(want.nearest_label),
                   64'(out_rsp.nearest_label));
        flag_field("nearest_x", 64'(want.nearest_x), 64'(out_rsp.nearest_x));
        flag_field("nearest_y", 64'(want.nearest_y), 64'(out_rsp.nearest_y));
        flag_field("squared_distance", 64'(want.squared_distance),
                   64'(out_rsp.squared_distance));
        flag_field("all_visited", 64'(want.all_visited),
                   64'(out_rsp.all_visited));
      end
    end
  end

  // every slot written once while the scan covers no slots
  task automatic test_fill_table();
    out_rsp_t want;
    set_pacing(1'b1, 20);
    send_req(make_req(OP_WRITE, 0, -16'sd32768, 16'sd32767, 16'h0000), want);
    for (int s = 1; s < MAX_PTS - 1; s++)
      send_req(make_req(OP_WRITE, s, rand_coord(1'($urandom_range(0, 1))),
                        rand_coord(1'($urandom_range(0, 1))),
                        LABEL_W'($urandom_range(0, 65535))), want);
    send_req(make_req(OP_WRITE, MAX_PTS - 1, 16'sd32767, -16'sd32768,
                      16'hFFFF), want);
  endtask

  task automatic test_empty_table();
    out_rsp_t want;
    set_pacing(1'b0, 0);
    set_points(0);
    send_req(make_req(OP_QUERY, 0, 16'sd0, 16'sd0, 16'h0000), want);
    send_req(make_req(OP_MARK, 0, 16'sd0, 16'sd0, 16'h0000), want);
    send_req(make_req(OP_CLEAR, 0, 16'sd0, 16'sd0, 16'h0000), want);
  endtask

  task automatic test_directed();
    out_rsp_t want;
    set_pacing(1'b0, 0);
    set_points(4);
    send_req(make_req(OP_WRITE, 0, -16'sd32768, -16'sd32768, 16'h0000), want);
    send_req(make_req(OP_WRITE, 1, 16'sd32767, 16'sd32767, 16'hFFFF), want);
    send_req(make_req(OP_WRITE, 2, 16'sd5, -16'sd3, 16'h1234), want);
    send_req(make_req(OP_WRITE, 3, 16'sd5, -16'sd3, 16'h4321), want);
    // equal distances: lowest slot wins
    send_req(make_req(OP_QUERY, 0, 16'sd5, -16'sd3, 16'h0000), want);
    send_req(make_req(OP_QUERY, 0, 16'sd32767, 16'sd32767, 16'h0000), want);
    send_req(make_req(OP_MARK, 1, 16'sd0, 16'sd0, 16'h0000), want);
    send_req(make_req(OP_MARK, 2, 16'sd0, 16'sd0, 16'h0000), want);
    send_req(make_req(OP_MARK, 0, 16'sd0, 16'sd0, 16'h0000), want);
    send_req(make_req(OP_QUERY, 0, -16'sd32768, -16'sd32768, 16'h0000), want);
    send_req(make_req(OP_MARK, 3, 16'sd0, 16'sd0, 16'h0000), want);
    // nothing left unvisited
    send_req(make_req(OP_QUERY, 0, 16'sd0, 16'sd0, 16'h0000), want);
    // rewrite clears the visited flag; farthest possible distance
    send_req(make_req(OP_WRITE, 1, 16'sd32767, 16'sd32767, 16'hFFFF), want);
    send_req(make_req(OP_QUERY, 0, -16'sd32768, -16'sd32768, 16'hFFFF), want);
    send_req(make_req(OP_CLEAR, 0, 16'sd0, 16'sd0, 16'h0000), want);
    send_req(make_req(OP_QUERY, 0, -16'sd1, -16'sd1, 16'h0000), want);
    // top slot sits outside the scan
    send_req(make_req(OP_WRITE, 255, -16'sd1, -16'sd1, 16'hAAAA), want);
    send_req(make_req(OP_MARK, 255, 16'sd0, 16'sd0, 16'h0000), want);
    send_req(make_req(OP_CLEAR, 255, 16'sd0, 16'sd0, 16'h0000), want);
  endtask

  task automatic test_clamp();
    out_rsp_t want;
    set_pacing(1'b0, 0);
    set_points(511);
    send_req(make_req(OP_QUERY, 0, rand_coord(1'b0), rand_coord(1'b0), 16'h0000),
             want);
    set_points(257);
    send_req(make_req(OP_MARK, 255, 16'sd0, 16'sd0, 16'h0000), want);
    send_req(make_req(OP_QUERY, 0, 16'sd32767, -16'sd32768, 16'h0000), want);
    send_req(make_req(OP_CLEAR, 255, 16'sd0, 16'sd0, 16'h0000), want);
    set_points(256);
    send_req(make_req(OP_QUERY, 0, 16'sd32767, -16'sd32768, 16'h0000), want);
  endtask

  // greedy tour: query from the last point, mark it, until none is left
  task automatic test_tour(input int n);
    out_rsp_t                  want;
    out_rsp_t                  mark_rsp;
    bit                        near;
    logic signed [COORD_W-1:0] qx, qy;
    set_points(n);
    set_pacing(1'($urandom_range(0, 1)), 25);
    near = 1'($urandom_range(0, 1));
    for (int s = 0; s < n; s++) begin
      if ($urandom_range(0, 1))
        send_req(make_req(OP_WRITE, s, rand_coord(near), rand_coord(near),
                          LABEL_W'($urandom_range(0, 65535))), want);
      else
        send_req(make_req(OP_CLEAR, s, rand_coord(1'b0), rand_coord(1'b0),
                          LABEL_W'($urandom_range(0, 65535))), want);
    end
    qx = rand_coord(near);
    qy = rand_coord(near);
    do begin
      send_req(make_req(OP_QUERY, $urandom_range(0, 255), qx, qy,
                        LABEL_W'($urandom_range(0, 65535))), want);
      if (want.found) begin
        qx = want.nearest_x;
        qy = want.nearest_y;
        send_req(make_req(OP_MARK, int'(want.nearest_slot), rand_coord(1'b0),
                          rand_coord(1'b0), LABEL_W'($urandom_range(0, 65535))),
                 mark_rsp);
      end
    end while (want.found);
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_backpressure();
    out_rsp_t want;
    set_points(6);
    set_pacing(1'b0, 0);
    hold_pending = 1'b1;
    for (int k = 0; k < 10; k++)
      send_req(make_req(op_t'($urandom_range(0, 3)), $urandom_range(0, 5),
                        rand_coord(1'b1), rand_coord(1'b1),
                        LABEL_W'($urandom_range(0, 65535))), want);
  endtask

  task automatic test_random_mix(input int n, input int count);
    out_rsp_t want;
    int       eff, k, s;
    op_t      op;
    set_points(n);
    set_pacing($urandom_range(0, 3) != 0, $urandom_range(0, 2) * 25);
    eff = (n > MAX_PTS) ? MAX_PTS : n;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      s = (eff > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, eff - 1)
                                                  : $urandom_range(0, 255);
      if (k < 35)      op = OP_QUERY;
      else if (k < 60) op = OP_MARK;
      else if (k < 75) op = OP_CLEAR;
      else             op = OP_WRITE;
      send_req(make_req(op, s, rand_coord(1'($urandom_range(0, 1))),
                        rand_coord(1'($urandom_range(0, 1))),
                        LABEL_W'($urandom_range(0, 65535))), want);
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_PTS; i++) pt_visited[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_fill_table();
    test_empty_table();
    test_directed();
    test_clamp();
    test_tour(1);
    test_tour(5);
    test_tour(24);
    test_tour(100);
    test_backpressure();
    test_random_mix(2, 55);
    test_random_mix(9, 55);
    test_random_mix(33, 55);
    test_random_mix(0, 30);
    test_random_mix(64, 55);
    test_random_mix(1, 40);
    test_random_mix(256, 25);
    test_random_mix(300, 25);
    test_random_mix(17, 55);
    wait_drain();
    if (mismatches == 0 && rsp_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
